[sv/pcxrle_pkg.sv]
// ----------------------------------------------------------------------------
// pcxrle_pkg
// Shared constants and controller/datapath interface types for the PCX
// run-length line decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package pcxrle_pkg;

  localparam int MAX_LINE_DEF = 4096;

  localparam int REG_W   = 13;
  localparam int ADDR_W  = 24;
  localparam int BYTE_W  = 8;
  localparam int RUN_W   = 6;
  localparam int IDX_W   = 2;

  // bytes above this mark carry a run count
  localparam logic [BYTE_W-1:0] RUN_MARK = 8'd191;
  localparam logic [BYTE_W-1:0] RUN_BASE = 8'd192;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [IDX_W-1:0] REG_DISPLAY_WIDTH  = 2'd2;
  localparam logic [IDX_W-1:0] REG_DISPLAY_HEIGHT = 2'd3;

  localparam logic [REG_W-1:0] IMAGE_WIDTH_RST    = 13'd640;
  localparam logic [REG_W-1:0] IMAGE_HEIGHT_RST   = 13'd480;
  localparam logic [REG_W-1:0] DISPLAY_WIDTH_RST  = 13'd640;
  localparam logic [REG_W-1:0] DISPLAY_HEIGHT_RST = 13'd480;

  // commands from the controller
  typedef struct packed {
    logic place;        // place one pixel this cycle
    logic use_run;      // pixel comes from the run value, not the input byte
    logic load_run;     // value byte arrived: start a run
    logic drop_run;     // value byte of an empty run: just clear the code
    logic load_pending; // run code byte arrived
  } dp_cmd_t;

  // status back to the controller
  typedef struct packed {
    logic finished;
    logic awaiting;
    logic pending_zero;
    logic is_run_code;
    logic can_emit;
    logic run_last;
  } dp_status_t;

endpackage

`default_nettype wire

[sv/pcxrle_ctrl.sv]
// ----------------------------------------------------------------------------
// pcxrle_ctrl
// Sequencer: takes input bytes while idle and the output can take a pixel,
// and steps through runs one pixel per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module pcxrle_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire pcxrle_pkg::dp_status_t  status,
  output pcxrle_pkg::dp_cmd_t          cmd
);
  import pcxrle_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state;
  logic state_next;
  logic accept;

  assign in_ready = (state == ST_IDLE) && status.can_emit;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (accept && !status.finished) begin
          if (status.awaiting) begin
            if (status.pending_zero) begin
              cmd.drop_run = 1'b1;
            end else begin
              cmd.load_run = 1'b1;
              state_next   = ST_RUN;
            end
          end else if (status.is_run_code) begin
            cmd.load_pending = 1'b1;
          end else begin
            cmd.place = 1'b1;
          end
        end
      end
      ST_RUN: begin
        if (status.can_emit) begin
          cmd.place   = 1'b1;
          cmd.use_run = 1'b1;
          if (status.run_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

[sv/pcxrle_dp.sv]
// ----------------------------------------------------------------------------
// pcxrle_dp
// Datapath: configuration registers, run state, column/row tracking,
// address generation and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pcxrle_dp #(
  parameter int MAX_LINE = pcxrle_pkg::MAX_LINE_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  input  wire logic [pcxrle_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [pcxrle_pkg::REG_W-1:0]   cfg_data,
  input  wire logic [pcxrle_pkg::BYTE_W-1:0]  in_byte,
  input  wire pcxrle_pkg::dp_cmd_t            cmd,
  output pcxrle_pkg::dp_status_t              status,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [pcxrle_pkg::BYTE_W-1:0]       out_value,
  output logic [pcxrle_pkg::ADDR_W-1:0]       out_addr,
  output logic                                out_last,
  output logic                                out_done
);
  import pcxrle_pkg::*;

  logic [REG_W-1:0]  image_width;
  logic [REG_W-1:0]  image_height;
  logic [REG_W-1:0]  display_width;
  logic [REG_W-1:0]  display_height;

  logic              awaiting;
  logic [RUN_W-1:0]  pending;
  logic [RUN_W-1:0]  run_cnt;
  logic [BYTE_W-1:0] run_value;
  logic [REG_W-1:0]  column;
  logic [REG_W-1:0]  row;
  logic [ADDR_W-1:0] row_base;
  logic              finished;

  logic [REG_W-1:0]  iw_eff;
  logic [REG_W-1:0]  ih_eff;
  logic [REG_W-1:0]  dw_eff;
  logic [REG_W-1:0]  dh_eff;
  logic [REG_W-1:0]  line_len;
  logic [REG_W-1:0]  rows_total;
  logic [REG_W-1:0]  vis_len;
  logic [REG_W-1:0]  col_inc;
  logic [REG_W-1:0]  row_inc;
  logic [REG_W:0]    col_p1;
  logic [REG_W:0]    row_p1;
  logic              line_end;
  logic              visible;
  logic              pix_done;
  logic              pix_last;
  logic              rows_end;
  logic [BYTE_W-1:0] pix_value;

  // zero registers count as one
  assign iw_eff = (image_width == '0)    ? REG_W'(1) : image_width;
  assign ih_eff = (image_height == '0)   ? REG_W'(1) : image_height;
  assign dw_eff = (display_width == '0)  ? REG_W'(1) : display_width;
  assign dh_eff = (display_height == '0) ? REG_W'(1) : display_height;

  assign line_len   = (32'(iw_eff) > 32'(MAX_LINE)) ? REG_W'(MAX_LINE) : iw_eff;
  assign rows_total = (ih_eff < dh_eff) ? ih_eff : dh_eff;
  assign vis_len    = (line_len < dw_eff) ? line_len : dw_eff;

  assign col_inc  = column + REG_W'(1);
  assign row_inc  = row + REG_W'(1);
  assign col_p1   = {1'b0, column} + (REG_W+1)'(1);
  assign row_p1   = {1'b0, row} + (REG_W+1)'(1);
  assign line_end = (col_inc >= line_len) || (col_inc == '0);
  assign rows_end = (row_inc >= rows_total) || (row_inc == '0);
  assign visible  = column < dw_eff;
  assign pix_done = (row_p1 == {1'b0, rows_total}) && (col_p1 == {1'b0, vis_len});

  // columns only grow inside a run, so once the next one is clipped
  // nothing further of this run is visible
  assign pix_last = !cmd.use_run || (run_cnt == RUN_W'(1)) || line_end ||
                    (col_inc >= dw_eff);

  assign pix_value = cmd.use_run ? run_value : in_byte;

  assign status.finished     = finished;
  assign status.awaiting     = awaiting;
  assign status.pending_zero = (pending == '0);
  assign status.is_run_code  = in_byte > RUN_MARK;
  assign status.can_emit     = !out_valid || out_ready;
  assign status.run_last     = (run_cnt == RUN_W'(1)) || line_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= IMAGE_WIDTH_RST;
      image_height   <= IMAGE_HEIGHT_RST;
      display_width  <= DISPLAY_WIDTH_RST;
      display_height <= DISPLAY_HEIGHT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:    image_width    <= cfg_data;
        REG_IMAGE_HEIGHT:   image_height   <= cfg_data;
        REG_DISPLAY_WIDTH:  display_width  <= cfg_data;
        REG_DISPLAY_HEIGHT: display_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting  <= 1'b0;
      pending   <= '0;
      run_cnt   <= '0;
      column    <= '0;
      row       <= '0;
      row_base  <= '0;
      finished  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_pending) begin
        awaiting <= 1'b1;
        pending  <= RUN_W'(in_byte - RUN_BASE);
      end
      if (cmd.load_run || cmd.drop_run) begin
        awaiting <= 1'b0;
        pending  <= '0;
      end
      if (cmd.load_run) begin
        run_cnt <= pending;
      end else if (cmd.place && cmd.use_run) begin
        run_cnt <= run_cnt - RUN_W'(1);
      end

      if (cmd.place) begin
        if (line_end) begin
          column   <= '0;
          row      <= row_inc;
          row_base <= row_base + ADDR_W'(dw_eff);
          if (rows_end) begin
            finished <= 1'b1;
          end
        end else begin
          column <= col_inc;
        end
      end

      if (cmd.place && visible) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_run) begin
      run_value <= in_byte;
    end
    if (cmd.place && visible) begin
      out_value <= pix_value;
      out_addr  <= row_base + ADDR_W'(column);
      out_last  <= pix_last;
      out_done  <= pix_done;
    end
  end

  a_no_place_after_finish: assert property (@(posedge clk) disable iff (rst)
    finished |-> !cmd.place)
    else $error("pixel placed after decoding finished");

  a_run_count_live: assert property (@(posedge clk) disable iff (rst)
    (cmd.place && cmd.use_run) |-> (run_cnt != '0))
    else $error("run step with empty run count");

  a_last_row_finishes: assert property (@(posedge clk) disable iff (rst)
    (cmd.place && line_end && rows_end) |=> finished)
    else $error("last row did not end decoding");

endmodule

`default_nettype wire

[sv/pcx_rle_line_decoder_core.sv]
// ----------------------------------------------------------------------------
// pcx_rle_line_decoder_core
// PCX 8-bit run-length decoder producing pixels with frame buffer addresses.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one compressed byte per beat. m_axis carries one decoded
//   pixel per beat: value and frame buffer address in tdata, tlast on the
//   final pixel caused by an input byte, tuser set on the last pixel of the
//   last decoded row. cfg writes one of four 13-bit size registers and is
//   always ready; write it only while the decoder is idle.
// Timing:
//   a literal byte or a run code byte is taken while the sequencer is idle.
//   A value byte loads the run, which then places pixels up to the run
//   length or the line end; the run sequencer places one pixel per cycle
//   while m_axis is not stalled. Clipped pixels are still stepped through.
//   A literal's pixel is valid the cycle after its byte is taken; a run's
//   pixels start once its value byte is registered into the run state.
// Reset:
//   sizes return to 640x480 image and display, position to row 0 column 0.
//   After the last row every byte is accepted and dropped until reset.
// Stall:
//   one output register; while m_axis is stalled with a pixel pending, no
//   byte is accepted and runs pause.
// ----------------------------------------------------------------------------
`default_nettype none

module pcx_rle_line_decoder_core #(
  parameter int MAX_LINE = pcxrle_pkg::MAX_LINE_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [pcxrle_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [pcxrle_pkg::REG_W-1:0]  cfg_data,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [7:0]                    s_axis_tdata,   // compressed_byte
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [31:0]                        m_axis_tdata,   // pixel_value, pixel_address
  output logic                               m_axis_tlast,   // last_of_item
  output logic                               m_axis_tuser    // image_done
);
  import pcxrle_pkg::*;

  dp_cmd_t            cmd;
  dp_status_t         status;
  logic [BYTE_W-1:0]  out_value;
  logic [ADDR_W-1:0]  out_addr;

  assign cfg_ready = 1'b1;

  pcxrle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  pcxrle_dp #(
    .MAX_LINE (MAX_LINE)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_byte   (s_axis_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_value (out_value),
    .out_addr  (out_addr),
    .out_last  (m_axis_tlast),
    .out_done  (m_axis_tuser)
  );

  assign m_axis_tdata = {out_addr, out_value};

endmodule

`default_nettype wire

[tb/pcx_rle_line_decoder_core_tb.sv]
// ----------------------------------------------------------------------------
// pcx_rle_line_decoder_core_tb
// Self-checking bench for the PCX run-length line decoder. A table of directed
// bytes covers literals, empty and overlong runs, clipping, zero sizes and a
// size change mid-line. Then come a widest-pitch pass, a line held to the
// maximum length, random sized passes and a closing pass that ends the image.
// Every pixel beat is checked field by field against a behavioral decoder.
// ----------------------------------------------------------------------------
module pcx_rle_line_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pcxrle_pkg::*;

  localparam int IDLE_PCT     = 19;
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int REG_MAX      = (1 << REG_W) - 1;
  localparam int HEIGHT_FLOOR = 3000;
  localparam int PITCH_BYTES  = 32;
  localparam int LONG_RUNS    = 66;
  localparam int RANDOM_BYTES = 16;
  localparam int PLAN_LEN     = 21;
  localparam logic [6:0] NPX_FREE = 7'h7F;
  localparam logic [BYTE_W-1:0] LONGEST_RUN = RUN_BASE + 8'd63;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic [ADDR_W-1:0] addr;
    logic              last;
    logic              done;
  } pixel_t;

  typedef enum logic {ROW_BYTE, ROW_SIZES} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [BYTE_W-1:0] data;
    logic [REG_W-1:0]  iw, ih, dw, dh;
    logic [6:0]        npx;    // pixels this byte makes, NPX_FREE if not typed in
    logic [BYTE_W-1:0] value;  // fields of its final pixel
    logic [ADDR_W-1:0] addr;
    logic              done;
  } plan_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [IDX_W-1:0]    cfg_index = '0;
  logic [REG_W-1:0]    cfg_data = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [31:0]         m_axis_tdata;
  logic                m_axis_tlast;
  logic                m_axis_tuser;

  // decoder model state
  logic [REG_W-1:0]  img_w  = IMAGE_WIDTH_RST;
  logic [REG_W-1:0]  img_h  = IMAGE_HEIGHT_RST;
  logic [REG_W-1:0]  disp_w = DISPLAY_WIDTH_RST;
  logic [REG_W-1:0]  disp_h = DISPLAY_HEIGHT_RST;
  logic              want_value = 1'b0;
  logic [RUN_W-1:0]  run_len = '0;
  logic [REG_W-1:0]  col = '0;
  logic [REG_W-1:0]  row = '0;
  logic [ADDR_W-1:0] row_base = '0;
  logic              image_over = 1'b0;

  pixel_t    pending_pixels [$];
  pixel_t    staged [$];
  plan_row_t plan [PLAN_LEN];
  int        errors = 0;
  int        cycles = 0;
  bit        steady = 1'b0;

  pcx_rle_line_decoder_core uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  task automatic flag_mismatch(input string what, input logic [39:0] want,
                               input logic [39:0] got);
    if (errors < 40) begin
      $display("mismatch %s: want %0h got %0h", what, want, got);
    end
    errors++;
  endtask

  // ---------------- behavioral decoder ----------------

  function automatic int floor_one(input logic [REG_W-1:0] v);
    return (v == 0) ? 1 : int'(v);
  endfunction

  function automatic int line_span();
    int w;
    w = floor_one(img_w);
    return (w > MAX_LINE_DEF) ? MAX_LINE_DEF : w;
  endfunction

  function automatic int row_limit();
    int ih, dh;
    ih = floor_one(img_h);
    dh = floor_one(disp_h);
    return (ih < dh) ? ih : dh;
  endfunction

  // returns 1 when the pixel closes its line
  function automatic bit place_pixel(input logic [BYTE_W-1:0] v);
    int     w, dw, h, vis;
    pixel_t p;
    w   = line_span();
    dw  = floor_one(disp_w);
    h   = row_limit();
    vis = (w < dw) ? w : dw;
    if (col < dw) begin
      p.value = v;
      p.addr  = row_base + col;
      p.last  = 1'b0;
      p.done  = (row + 1 == h) && (col + 1 == vis);
      staged.push_back(p);
    end
    col = col + 1'b1;
    if (col >= w || col == 0) begin
      col      = '0;
      row      = row + 1'b1;
      row_base = row_base + ADDR_W'(dw);
      if (row >= h || row == 0) image_over = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void decode_byte(input logic [BYTE_W-1:0] b, output int n);
    n = 0;
    staged.delete();
    if (image_over) return;
    if (want_value) begin
      want_value = 1'b0;
      for (int i = 0; i < run_len; i++) begin
        if (place_pixel(b)) break;
      end
      run_len = '0;
    end else if (b > RUN_MARK) begin
      run_len    = RUN_W'(b - RUN_BASE);
      want_value = 1'b1;
    end else begin
      void'(place_pixel(b));
    end
    n = staged.size();
    if (n > 0) staged[n-1].last = 1'b1;
    foreach (staged[i]) pending_pixels.push_back(staged[i]);
  endfunction

  function automatic void set_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] v);
    case (idx)
      REG_IMAGE_WIDTH:    img_w  = v;
      REG_IMAGE_HEIGHT:   img_h  = v;
      REG_DISPLAY_WIDTH:  disp_w = v;
      REG_DISPLAY_HEIGHT: disp_h = v;
      default: ;
    endcase
  endfunction

  // ---------------- stimulus ----------------

  function automatic plan_row_t byte_row(input logic [7:0] b, input logic [6:0] n,
                                         input logic [7:0] v, input logic [23:0] a,
                                         input logic d);
    plan_row_t r;
    r       = '0;
    r.kind  = ROW_BYTE;
    r.data  = b;
    r.npx   = n;
    r.value = v;
    r.addr  = a;
    r.done  = d;
    return r;
  endfunction

  function automatic plan_row_t quiet_row(input logic [7:0] b);
    return byte_row(b, 7'd0, 8'h00, 24'd0, 1'b0);
  endfunction

  function automatic plan_row_t size_row(input logic [REG_W-1:0] iw, ih, dw, dh);
    plan_row_t r;
    r      = '0;
    r.kind = ROW_SIZES;
    r.iw   = iw;
    r.ih   = ih;
    r.dw   = dw;
    r.dh   = dh;
    return r;
  endfunction

  function automatic logic [REG_W-1:0] pick_width(input bit for_display);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return REG_W'(1);
      2: return REG_W'($urandom_range(2, 16));
      3: return REG_W'($urandom_range(17, 200));
      4: return for_display ? REG_W'(REG_MAX) : REG_W'(MAX_LINE_DEF);
      default: return REG_W'($urandom_range(MAX_LINE_DEF + 1, REG_MAX));
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, output int n);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    decode_byte(b, n);
  endtask

  // mostly run pairs and literals, with now and then a stray byte of any kind
  task automatic send_random(input int count);
    int left, n;
    left = count;
    while (left > 0) begin
      if (left > 1 && $urandom_range(0, 1) == 1) begin
        send_byte(8'($urandom_range(RUN_BASE, 255)), n);
        send_byte(8'($urandom_range(0, 255)), n);
        left -= 2;
      end else begin
        if ($urandom_range(0, 9) == 0) send_byte(8'($urandom_range(0, 255)), n);
        else send_byte(8'($urandom_range(0, RUN_MARK)), n);
        left--;
      end
    end
  endtask

  // input side lowered, every pixel out, then room for clipped run cycles
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_sizes(input logic [REG_W-1:0] iw, ih, dw, dh);
    logic [REG_W-1:0] vals [4];
    logic [IDX_W-1:0] idx [4];
    vals = '{iw, ih, dw, dh};
    idx  = '{REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_DISPLAY_WIDTH, REG_DISPLAY_HEIGHT};
    for (int k = 0; k < 4; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= vals[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      set_reg(idx[k], vals[k]);
    end
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // ---------------- pixel checker ----------------

  always @(posedge clk) begin
    pixel_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_pixels.size() == 0) begin
        flag_mismatch("unexpected pixel beat", '0, {m_axis_tuser, m_axis_tlast, m_axis_tdata});
      end else begin
        want = pending_pixels.pop_front();
        if (m_axis_tdata[7:0] !== want.value)
          flag_mismatch("pixel_value", want.value, m_axis_tdata[7:0]);
        if (m_axis_tdata[31:8] !== want.addr)
          flag_mismatch("pixel_address", want.addr, m_axis_tdata[31:8]);
        if (m_axis_tlast !== want.last)
          flag_mismatch("last_of_item", want.last, m_axis_tlast);
        if (m_axis_tuser !== want.done)
          flag_mismatch("image_done", want.done, m_axis_tuser);
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    int     n;
    pixel_t got;
    plan = '{
      // reset sizes: 640 wide image and display
      byte_row(8'h00, 7'd1, 8'h00, 24'd0, 1'b0),
      byte_row(8'hBF, 7'd1, 8'hBF, 24'd1, 1'b0),
      // zero heights count as one row; display narrower than the image
      size_row(13'd8, 13'd0, 13'd4, 13'd0),
      quiet_row(8'hC0),
      quiet_row(8'h55),
      byte_row(8'h7E, 7'd1, 8'h7E, 24'd2, 1'b0),
      byte_row(8'h81, 7'd1, 8'h81, 24'd3, 1'b1),
      // raise the heights before the line closes so decoding goes on
      size_row(13'd8, 13'd8191, 13'd4, 13'd4096),
      quiet_row(8'h11),
      quiet_row(8'hC1),
      quiet_row(8'h22),
      quiet_row(8'hC5),
      quiet_row(8'h33),
      quiet_row(8'hFF),
      byte_row(8'hFF, 7'd4, 8'hFF, 24'd7, 1'b0),
      quiet_row(8'hC3),
      byte_row(8'h00, 7'd3, 8'h00, 24'd10, 1'b0),
      // line shorter than the current column: next pixel closes the line
      size_row(13'd2, 13'd8191, 13'd8191, 13'd4096),
      byte_row(8'h40, 7'd1, 8'h40, 24'd11, 1'b0),
      quiet_row(8'hDF),
      byte_row(8'hC8, 7'd2, 8'hC8, 24'd8200, 1'b0)
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_SIZES) begin
        wait_idle();
        write_sizes(plan[i].iw, plan[i].ih, plan[i].dw, plan[i].dh);
      end else begin
        send_byte(plan[i].data, n);
        if (plan[i].npx != NPX_FREE) begin
          if (n != plan[i].npx) begin
            flag_mismatch("pixel count of directed byte", plan[i].npx, n);
          end else if (n > 0) begin
            got = pending_pixels[$];
            if ({got.done, got.addr, got.value} !== {plan[i].done, plan[i].addr, plan[i].value})
              flag_mismatch("directed pixel", {plan[i].done, plan[i].addr, plan[i].value},
                            {got.done, got.addr, got.value});
          end
        end
      end
    end

    // one-pixel lines at the widest pitch
    wait_idle();
    write_sizes(REG_W'(1), REG_W'(REG_MAX), REG_W'(REG_MAX), REG_W'(REG_MAX));
    repeat (PITCH_BYTES) send_byte(8'($urandom_range(0, RUN_MARK)), n);

    // image width beyond the line limit: the line still closes at the limit
    wait_idle();
    write_sizes(REG_W'(REG_MAX), REG_W'(REG_MAX), REG_W'(1), REG_W'(REG_MAX));
    repeat (LONG_RUNS) begin
      send_byte(LONGEST_RUN, n);
      send_byte(8'($urandom_range(0, 255)), n);
    end

    // heights stay far above the rows these passes can reach
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      steady = (p == 2);
      write_sizes(pick_width(1'b0), REG_W'($urandom_range(HEIGHT_FLOOR, REG_MAX)),
                  pick_width(1'b1),
                  ($urandom_range(0, 1) == 1) ? REG_W'(REG_MAX)
                                              : REG_W'($urandom_range(HEIGHT_FLOOR, REG_MAX)));
      send_random(RANDOM_BYTES);
    end

    // the current row becomes the last one; bytes after the end are dropped
    wait_idle();
    steady = 1'b0;
    write_sizes(REG_W'($urandom_range(1, 16)), row + 1'b1,
                REG_W'($urandom_range(1, 16)), REG_W'(REG_MAX));
    while (!image_over) send_random(2);
    send_random(12);

    wait_idle();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
sv/pcxrle_pkg.sv
sv/pcxrle_ctrl.sv
sv/pcxrle_dp.sv
sv/pcx_rle_line_decoder_core.sv
tb/pcx_rle_line_decoder_core_tb.sv
